[design/lic_pkg.sv]
// Shared constants and codes for the lidar point incidence classifier.
package lic_pkg;

   localparam int COORD_WIDTH_DEF = 32;

   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 32;

   localparam logic [CSR_IDX_W-1:0] REG_COS_LIMIT  = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_MAX_RANGE  = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_LOD_LIMIT  = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_INIT_SPOT  = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_DIVERGENCE = 3'd4;

   localparam logic [15:0] COS_LIMIT_RST  = 16'd16384;
   localparam logic [31:0] MAX_RANGE_RST  = 32'd1966080;
   localparam logic [31:0] LOD_LIMIT_RST  = 32'd9961;
   localparam logic [31:0] INIT_SPOT_RST  = 32'd655;
   localparam logic [23:0] DIVERGENCE_RST = 24'd50332;

   localparam int NORM_W     = 64;
   localparam int NORM_STEPS = 6;

   localparam logic [30:0] ONE_Q30 = 31'h4000_0000;

   typedef enum logic [2:0] {
      CLS_KEEP  = 3'd0,
      CLS_ANGLE = 3'd1,
      CLS_SPOT  = 3'd2,
      CLS_BOTH  = 3'd3,
      CLS_RANGE = 3'd4,
      CLS_SKIP  = 3'd5
   } class_type;

endpackage

[design/lic_isqrt.sv]
// Pipelined integer square root, one result bit per stage.
module lic_isqrt #(
   parameter int RAD_W = 64,
   parameter int SB_W  = 1
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 en,
   input  logic                 in_valid,
   input  logic [RAD_W-1:0]     in_rad,
   input  logic [SB_W-1:0]      in_sb,
   output logic                 out_valid,
   output logic [RAD_W/2-1:0]   out_root,
   output logic [SB_W-1:0]      out_sb
);

   localparam int STEPS = RAD_W / 2;

   logic [RAD_W-1:0] rem_ff [1:STEPS];
   logic [RAD_W-1:0] res_ff [1:STEPS];
   logic [SB_W-1:0]  sb_ff  [1:STEPS];
   logic             vld_ff [1:STEPS];

   for (genvar k = 0; k < STEPS; k++) begin : g_step
      localparam logic [RAD_W-1:0] BIT = RAD_W'(1) << (RAD_W - 2 - 2 * k);
      logic [RAD_W-1:0] rem_i;
      logic [RAD_W-1:0] res_i;
      logic [SB_W-1:0]  sb_i;
      logic             vld_i;
      logic [RAD_W-1:0] trial;
      logic             ge;

      if (k == 0) begin : g_first
         assign rem_i = in_rad;
         assign res_i = '0;
         assign sb_i  = in_sb;
         assign vld_i = in_valid;
      end else begin : g_next
         assign rem_i = rem_ff[k];
         assign res_i = res_ff[k];
         assign sb_i  = sb_ff[k];
         assign vld_i = vld_ff[k];
      end

      assign trial = res_i + BIT;
      assign ge    = (rem_i >= trial);

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[k+1] <= 1'b0;
         end else if (en) begin
            vld_ff[k+1] <= vld_i;
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff[k+1] <= ge ? (rem_i - trial) : rem_i;
            res_ff[k+1] <= ge ? ((res_i >> 1) + BIT) : (res_i >> 1);
            sb_ff[k+1]  <= sb_i;
         end
      end
   end

   assign out_valid = vld_ff[STEPS];
   assign out_root  = res_ff[STEPS][RAD_W/2-1:0];
   assign out_sb    = sb_ff[STEPS];

endmodule

[design/lic_div.sv]
// Pipelined restoring divider, one quotient bit per stage.
module lic_div #(
   parameter int NUM_W = 64,
   parameter int DEN_W = 32,
   parameter int Q_W   = 32,
   parameter int SB_W  = 1
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             en,
   input  logic             in_valid,
   input  logic [NUM_W-1:0] in_num,
   input  logic [DEN_W-1:0] in_den,
   input  logic [SB_W-1:0]  in_sb,
   output logic             out_valid,
   output logic [Q_W-1:0]   out_quot,
   output logic [SB_W-1:0]  out_sb
);

   logic [NUM_W-1:0] rem_ff [1:Q_W];
   logic [DEN_W-1:0] den_ff [1:Q_W];
   logic [Q_W-1:0]   quo_ff [1:Q_W];
   logic [SB_W-1:0]  sb_ff  [1:Q_W];
   logic             vld_ff [1:Q_W];

   for (genvar k = 0; k < Q_W; k++) begin : g_step
      localparam int SH = Q_W - 1 - k;
      logic [NUM_W-1:0] rem_i;
      logic [DEN_W-1:0] den_i;
      logic [Q_W-1:0]   quo_i;
      logic [SB_W-1:0]  sb_i;
      logic             vld_i;
      logic [NUM_W-1:0] dsh;
      logic             ge;

      if (k == 0) begin : g_first
         assign rem_i = in_num;
         assign den_i = in_den;
         assign quo_i = '0;
         assign sb_i  = in_sb;
         assign vld_i = in_valid;
      end else begin : g_next
         assign rem_i = rem_ff[k];
         assign den_i = den_ff[k];
         assign quo_i = quo_ff[k];
         assign sb_i  = sb_ff[k];
         assign vld_i = vld_ff[k];
      end

      assign dsh = NUM_W'(den_i) << SH;
      assign ge  = (rem_i >= dsh);

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[k+1] <= 1'b0;
         end else if (en) begin
            vld_ff[k+1] <= vld_i;
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff[k+1] <= ge ? (rem_i - dsh) : rem_i;
            den_ff[k+1] <= den_i;
            quo_ff[k+1] <= {quo_i[Q_W-2:0], ge};
            sb_ff[k+1]  <= sb_i;
         end
      end
   end

   assign out_valid = vld_ff[Q_W];
   assign out_quot  = quo_ff[Q_W];
   assign out_sb    = sb_ff[Q_W];

endmodule

[design/lidar_point_incidence_classifier.sv]
// Top level of the lidar point incidence classifier pipeline.
//
// A point enters on the req_ channel (valid/ready) with its normal and the sensor
// position, and leaves on the rsp_ channel with its coordinates, a class code, the
// flat-normal flag and the scan-end mark. Registers are written on the csr_ channel,
// which is always ready; index 0 to 4 select the cosine limit, range limit, spot
// limit, initial spot and beam divergence, and other indexes are ignored.
// One point is accepted per cycle while req_ready is high. An accepted beat passes
// through the difference, magnitude and normalization stages, three product
// stages, a 32-stage square root for range and denominator in parallel,
// a 32-stage divider for the incidence cosine and three stages of tests.
// The whole pipeline advances together; while a result waits and rsp_ready is
// low, every stage holds and req_ready is low. Reset empties the pipeline and
// loads the register defaults.
module lidar_point_incidence_classifier import lic_pkg::*; #(
   parameter int COORD_WIDTH = COORD_WIDTH_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic signed [COORD_WIDTH-1:0] req_point_x,
   input  logic signed [COORD_WIDTH-1:0] req_point_y,
   input  logic signed [COORD_WIDTH-1:0] req_point_z,
   input  logic                          req_point_finite,
   input  logic signed [15:0]            req_normal_x,
   input  logic signed [15:0]            req_normal_y,
   input  logic signed [15:0]            req_normal_z,
   input  logic signed [COORD_WIDTH-1:0] req_sensor_x,
   input  logic signed [COORD_WIDTH-1:0] req_sensor_y,
   input  logic signed [COORD_WIDTH-1:0] req_sensor_z,
   input  logic                          req_scan_end,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic signed [COORD_WIDTH-1:0] rsp_out_x,
   output logic signed [COORD_WIDTH-1:0] rsp_out_y,
   output logic signed [COORD_WIDTH-1:0] rsp_out_z,
   output logic [2:0]                    rsp_class_code,
   output logic                          rsp_flat_normal,
   output logic                          rsp_scan_end_out,
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [CSR_IDX_W-1:0]          csr_index,
   input  logic [CSR_DATA_W-1:0]         csr_data
);

   localparam int W  = COORD_WIDTH;
   localparam int DW = COORD_WIDTH + 1;

   typedef struct packed {
      logic [W-1:0] px;
      logic [W-1:0] py;
      logic [W-1:0] pz;
      logic         fin;
      logic         last;
      logic         flat;
   } pay_type;

   typedef struct packed {
      pay_type      pay;
      logic         sgx;
      logic         sgy;
      logic [15:0]  nx;
      logic [15:0]  ny;
      logic         zero;
      logic         big;
      logic [63:0]  sqx;
      logic [63:0]  sqy;
      logic [63:0]  sqz;
      logic [63:0]  rad;
      logic         rsat;
   } side_type;

   typedef struct packed {
      logic [NORM_W-1:0] nu;
      logic [NORM_W-1:0] nv;
   } nrm_type;

   typedef struct packed {
      pay_type     pay;
      logic        zero;
      logic [32:0] adot;
   } csb_type;

   typedef struct packed {
      pay_type     pay;
      logic        zero;
      logic [31:0] rng;
   } dsb_type;

   logic [15:0] cal_ff;
   logic [31:0] mrange_ff;
   logic [31:0] lod_ff;
   logic [31:0] ispot_ff;
   logic [23:0] bdiv_ff;

   logic en;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cal_ff    <= COS_LIMIT_RST;
         mrange_ff <= MAX_RANGE_RST;
         lod_ff    <= LOD_LIMIT_RST;
         ispot_ff  <= INIT_SPOT_RST;
         bdiv_ff   <= DIVERGENCE_RST;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            REG_COS_LIMIT:  cal_ff    <= csr_data[15:0];
            REG_MAX_RANGE:  mrange_ff <= csr_data;
            REG_LOD_LIMIT:  lod_ff    <= csr_data;
            REG_INIT_SPOT:  ispot_ff  <= csr_data;
            REG_DIVERGENCE: bdiv_ff   <= csr_data[23:0];
            default: ;
         endcase
      end
   end

   assign en        = !rsp_valid || rsp_ready;
   assign req_ready = en;

   // Stage 1: differences to the sensor.
   logic                 v1_ff;
   logic signed [DW-1:0] dx1_ff, dy1_ff, dz1_ff;
   logic [15:0]          nx1_ff, ny1_ff;
   pay_type              pay1_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
      end else if (en) begin
         v1_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         dx1_ff       <= {req_point_x[W-1], req_point_x} - {req_sensor_x[W-1], req_sensor_x};
         dy1_ff       <= {req_point_y[W-1], req_point_y} - {req_sensor_y[W-1], req_sensor_y};
         dz1_ff       <= {req_point_z[W-1], req_point_z} - {req_sensor_z[W-1], req_sensor_z};
         nx1_ff       <= req_normal_x;
         ny1_ff       <= req_normal_y;
         pay1_ff.px   <= req_point_x;
         pay1_ff.py   <= req_point_y;
         pay1_ff.pz   <= req_point_z;
         pay1_ff.fin  <= req_point_finite;
         pay1_ff.last <= req_scan_end;
         pay1_ff.flat <= (req_normal_x == '0) && (req_normal_y == '0);
      end
   end

   // Stage 2: magnitudes.
   logic          v2_ff;
   logic [DW-1:0] ax2_ff, ay2_ff, az2_ff;
   logic          sgx2_ff, sgy2_ff;
   logic [15:0]   nx2_ff, ny2_ff;
   pay_type       pay2_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v2_ff <= 1'b0;
      end else if (en) begin
         v2_ff <= v1_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         ax2_ff  <= dx1_ff[DW-1] ? (~dx1_ff + 1'b1) : dx1_ff;
         ay2_ff  <= dy1_ff[DW-1] ? (~dy1_ff + 1'b1) : dy1_ff;
         az2_ff  <= dz1_ff[DW-1] ? (~dz1_ff + 1'b1) : dz1_ff;
         sgx2_ff <= dx1_ff[DW-1];
         sgy2_ff <= dy1_ff[DW-1];
         nx2_ff  <= nx1_ff;
         ny2_ff  <= ny1_ff;
         pay2_ff <= pay1_ff;
      end
   end

   // Stage 3 and the normalization stages.
   side_type side_ff [0:NORM_STEPS];
   nrm_type  nrm_ff  [0:NORM_STEPS];
   logic     vn_ff   [0:NORM_STEPS];

   logic [NORM_W-1:0] ax64, ay64, az64;
   side_type          side_in;

   assign ax64 = NORM_W'(ax2_ff);
   assign ay64 = NORM_W'(ay2_ff);
   assign az64 = NORM_W'(az2_ff);

   always_comb begin
      side_in      = '0;
      side_in.pay  = pay2_ff;
      side_in.sgx  = sgx2_ff;
      side_in.sgy  = sgy2_ff;
      side_in.nx   = nx2_ff;
      side_in.ny   = ny2_ff;
      side_in.zero = ((ax2_ff | ay2_ff) == '0);
      side_in.big  = (|ax64[NORM_W-1:32]) | (|ay64[NORM_W-1:32]) | (|az64[NORM_W-1:32]);
      side_in.sqx  = ax64[31:0] * ax64[31:0];
      side_in.sqy  = ay64[31:0] * ay64[31:0];
      side_in.sqz  = az64[31:0] * az64[31:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vn_ff[0] <= 1'b0;
      end else if (en) begin
         vn_ff[0] <= v2_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         side_ff[0]   <= side_in;
         nrm_ff[0].nu <= ax64;
         nrm_ff[0].nv <= ay64;
      end
   end

   for (genvar k = 1; k <= NORM_STEPS; k++) begin : g_norm
      localparam int SH = NORM_W >> k;
      logic [NORM_W-1:0] orv;
      side_type          side_nx;

      assign orv = nrm_ff[k-1].nu | nrm_ff[k-1].nv;

      if (k == 1) begin : g_sum
         logic [65:0] sum;
         assign sum = 66'(side_ff[0].sqx) + 66'(side_ff[0].sqy) + 66'(side_ff[0].sqz);
         always_comb begin
            side_nx      = side_ff[0];
            side_nx.rad  = sum[63:0];
            side_nx.rsat = side_ff[0].big | (|sum[65:64]);
         end
      end else begin : g_copy
         assign side_nx = side_ff[k-1];
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            vn_ff[k] <= 1'b0;
         end else if (en) begin
            vn_ff[k] <= vn_ff[k-1];
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            side_ff[k] <= side_nx;
            if (orv[NORM_W-1 -: SH] == '0) begin
               nrm_ff[k].nu <= nrm_ff[k-1].nu << SH;
               nrm_ff[k].nv <= nrm_ff[k-1].nv << SH;
            end else begin
               nrm_ff[k] <= nrm_ff[k-1];
            end
         end
      end
   end

   // Stage 10: products of the scaled direction and the normal.
   logic               v10_ff;
   logic signed [32:0] tx10_ff, ty10_ff;
   logic [31:0]        uxx10_ff, uyy10_ff, nxx10_ff, nyy10_ff;
   side_type           side10_ff;
   logic [15:0]        ux16, uy16;

   assign ux16 = nrm_ff[NORM_STEPS].nu[NORM_W-1 -: 16];
   assign uy16 = nrm_ff[NORM_STEPS].nv[NORM_W-1 -: 16];

   always_ff @(posedge clock) begin
      if (reset) begin
         v10_ff <= 1'b0;
      end else if (en) begin
         v10_ff <= vn_ff[NORM_STEPS];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         tx10_ff   <= $signed({1'b0, ux16}) * $signed(side_ff[NORM_STEPS].nx);
         ty10_ff   <= $signed({1'b0, uy16}) * $signed(side_ff[NORM_STEPS].ny);
         uxx10_ff  <= ux16 * ux16;
         uyy10_ff  <= uy16 * uy16;
         nxx10_ff  <= $signed(side_ff[NORM_STEPS].nx) * $signed(side_ff[NORM_STEPS].nx);
         nyy10_ff  <= $signed(side_ff[NORM_STEPS].ny) * $signed(side_ff[NORM_STEPS].ny);
         side10_ff <= side_ff[NORM_STEPS];
      end
   end

   // Stage 11: dot product and squared norms.
   logic               v11_ff;
   logic [32:0]        adot11_ff;
   logic [32:0]        dn211_ff;
   logic [31:0]        nn211_ff;
   side_type           side11_ff;
   logic signed [33:0] dtx, dty, dsum;

   assign dtx  = side10_ff.sgx ? -34'(tx10_ff) : 34'(tx10_ff);
   assign dty  = side10_ff.sgy ? -34'(ty10_ff) : 34'(ty10_ff);
   assign dsum = dtx + dty;

   always_ff @(posedge clock) begin
      if (reset) begin
         v11_ff <= 1'b0;
      end else if (en) begin
         v11_ff <= v10_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         adot11_ff <= dsum[33] ? 33'(-dsum) : 33'(dsum);
         dn211_ff  <= 33'(uxx10_ff) + 33'(uyy10_ff);
         nn211_ff  <= nxx10_ff + nyy10_ff;
         side11_ff <= side10_ff;
      end
   end

   // Stage 12: product under the denominator root.
   logic        v12_ff;
   logic [63:0] prod12_ff;
   side_type    side12_ff;
   logic [32:0] adot12_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v12_ff <= 1'b0;
      end else if (en) begin
         v12_ff <= v11_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         prod12_ff <= dn211_ff * nn211_ff;
         adot12_ff <= adot11_ff;
         side12_ff <= side11_ff;
      end
   end

   csb_type     csb_in, csb_out;
   logic        cs_valid, rs_valid;
   logic [31:0] den, root;
   logic        rsat_out;

   always_comb begin
      csb_in.pay  = side12_ff.pay;
      csb_in.zero = side12_ff.zero;
      csb_in.adot = adot12_ff;
   end

   lic_isqrt #(.RAD_W(64), .SB_W($bits(csb_type))) u_den_sqrt (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (v12_ff),
      .in_rad    (prod12_ff),
      .in_sb     (csb_in),
      .out_valid (cs_valid),
      .out_root  (den),
      .out_sb    (csb_out)
   );

   lic_isqrt #(.RAD_W(64), .SB_W(1)) u_rng_sqrt (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (v12_ff),
      .in_rad    (side12_ff.rad),
      .in_sb     (side12_ff.rsat),
      .out_valid (rs_valid),
      .out_root  (root),
      .out_sb    (rsat_out)
   );

   dsb_type     dsb_in, dsb_out;
   logic        dv_valid;
   logic [31:0] quot;

   always_comb begin
      dsb_in.pay  = csb_out.pay;
      dsb_in.zero = csb_out.zero || (den == '0);
      dsb_in.rng  = rsat_out ? '1 : root;
   end

   lic_div #(.NUM_W(64), .DEN_W(32), .Q_W(32), .SB_W($bits(dsb_type))) u_cos_div (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (cs_valid && rs_valid),
      .in_num    (64'({csb_out.adot, 30'b0})),
      .in_den    (den),
      .in_sb     (dsb_in),
      .out_valid (dv_valid),
      .out_quot  (quot),
      .out_sb    (dsb_out)
   );

   // Cosine clamp and angle test.
   logic        va_ff;
   logic [30:0] cosh_a_ff;
   logic        ang_a_ff;
   logic [31:0] rng_a_ff;
   pay_type     pay_a_ff;
   logic [30:0] cosh_in;

   always_comb begin
      if (dsb_out.pay.flat) begin
         cosh_in = ONE_Q30;
      end else if (dsb_out.zero) begin
         cosh_in = '0;
      end else if (quot > 32'(ONE_Q30)) begin
         cosh_in = ONE_Q30;
      end else begin
         cosh_in = quot[30:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         va_ff <= 1'b0;
      end else if (en) begin
         va_ff <= dv_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         cosh_a_ff <= cosh_in;
         ang_a_ff  <= dsb_out.pay.flat || (cosh_in <= {cal_ff, 15'b0});
         rng_a_ff  <= dsb_out.rng;
         pay_a_ff  <= dsb_out.pay;
      end
   end

   // Spot products and range test.
   logic        vm_ff;
   logic [55:0] sprod_m_ff;
   logic [62:0] lprod_m_ff;
   logic        ang_m_ff, far_m_ff;
   pay_type     pay_m_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         vm_ff <= 1'b0;
      end else if (en) begin
         vm_ff <= va_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         sprod_m_ff <= rng_a_ff * bdiv_ff;
         lprod_m_ff <= lod_ff * cosh_a_ff;
         ang_m_ff   <= ang_a_ff;
         far_m_ff   <= (rng_a_ff >= mrange_ff);
         pay_m_ff   <= pay_a_ff;
      end
   end

   // Output register.
   logic        rsp_valid_ff;
   logic [W-1:0] out_x_ff, out_y_ff, out_z_ff;
   class_type   code_ff;
   logic        flat_ff, last_ff;
   logic [63:0] spot;
   logic        spot_hit;
   class_type   code_in;

   assign spot     = 64'({ispot_ff, 30'b0}) + 64'({sprod_m_ff, 6'b0});
   assign spot_hit = (spot >= 64'(lprod_m_ff));

   always_comb begin
      priority if (!pay_m_ff.fin) begin
         code_in = CLS_SKIP;
      end else if (ang_m_ff && !spot_hit) begin
         code_in = CLS_ANGLE;
      end else if (!ang_m_ff && spot_hit) begin
         code_in = CLS_SPOT;
      end else if (ang_m_ff && spot_hit) begin
         code_in = CLS_BOTH;
      end else if (far_m_ff) begin
         code_in = CLS_RANGE;
      end else begin
         code_in = CLS_KEEP;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (en) begin
         rsp_valid_ff <= vm_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         out_x_ff <= pay_m_ff.px;
         out_y_ff <= pay_m_ff.py;
         out_z_ff <= pay_m_ff.pz;
         code_ff  <= code_in;
         flat_ff  <= pay_m_ff.fin && pay_m_ff.flat;
         last_ff  <= pay_m_ff.last;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_out_x        = out_x_ff;
   assign rsp_out_y        = out_y_ff;
   assign rsp_out_z        = out_z_ff;
   assign rsp_class_code   = code_ff;
   assign rsp_flat_normal  = flat_ff;
   assign rsp_scan_end_out = last_ff;

`ifndef ASSERT_OFF
   a_flat_is_angle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_flat_normal |-> rsp_class_code == CLS_ANGLE ||
                                       rsp_class_code == CLS_BOTH)
      else $error("flat normal without angle class");

   a_skip_not_flat: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_class_code == CLS_SKIP |-> !rsp_flat_normal)
      else $error("skipped point marked flat");

   a_cos_bound: assert property (@(posedge clock) disable iff (reset)
      va_ff |-> cosh_a_ff <= ONE_Q30)
      else $error("incidence cosine above one");

   a_sqrt_aligned: assert property (@(posedge clock) disable iff (reset)
      cs_valid == rs_valid)
      else $error("root pipelines out of step");

   a_reset_empty: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("result valid right after reset");
`endif

endmodule
